// File: rtl/bffa_pkg.sv
// Shared widths, codes and width helpers for the bitmap first-fit block allocator.
`default_nettype none

package bffa_pkg;

    // Default number of blocks held by the free map.
    localparam int NUM_BLOCKS_DEF = 64;

    // Fixed field widths of the request and response words.
    localparam int OPCODE_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef logic [OPCODE_W-1:0] opcode_t;

    // Request operation codes.
    localparam opcode_t OPC_ALLOC = 2'd0;
    localparam opcode_t OPC_FREE  = 2'd1;
    localparam opcode_t OPC_CHECK = 2'd2;

    // Response status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // Map update command from the sequencer to the map.
    typedef struct packed {
        logic upd;   // apply the range update this cycle
        logic set;   // 1 marks the range taken, 0 marks it free
    } bffa_upd_t;

    // Bits needed to address one block.
    function automatic int bffa_idx_w(input int n);
        return (n > 2) ? $clog2(n) : 1;
    endfunction

    // Bits of a run length: holds the block count and the request count field.
    function automatic int bffa_len_w(input int n);
        int cw;
        cw = $clog2(n + 1);
        return (cw > COUNT_W) ? cw : COUNT_W;
    endfunction

    // Bits of range arithmetic: start plus length never overflows.
    function automatic int bffa_rng_w(input int n);
        int iw;
        int lw;
        iw = bffa_idx_w(n);
        lw = bffa_len_w(n);
        return ((iw > lw) ? iw : lw) + 1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bffa_if.sv
// Request and response channel interfaces of the block allocator.
`default_nettype none

interface bffa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bffa_pkg::OPCODE_W-1:0] opcode;
    logic [bffa_pkg::INDEX_W-1:0]  block_index;
    logic [bffa_pkg::COUNT_W-1:0]  run_length;

    modport source (output valid, output opcode, output block_index, output run_length,
                    input ready);
    modport sink   (input valid, input opcode, input block_index, input run_length,
                    output ready);
endinterface

interface bffa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [bffa_pkg::INDEX_W-1:0] first_block;
    logic                         block_taken;

    modport source (output valid, output status, output first_block, output block_taken,
                    input ready);
    modport sink   (input valid, input status, input first_block, input block_taken,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/bffa_map.sv
// Free map register with a range set/clear update and two bit read ports.
`default_nettype none

module bffa_map #(
    parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire bffa_pkg::bffa_upd_t                       upd,
    input  wire logic [bffa_pkg::bffa_rng_w(NUM_BLOCKS)-1:0] lo,
    input  wire logic [bffa_pkg::bffa_rng_w(NUM_BLOCKS)-1:0] len,
    input  wire logic [bffa_pkg::bffa_idx_w(NUM_BLOCKS)-1:0] addr_a,
    input  wire logic [bffa_pkg::bffa_idx_w(NUM_BLOCKS)-1:0] addr_b,
    output logic                                           bit_a,
    output logic                                           bit_b
);

    localparam int MW = bffa_pkg::bffa_rng_w(NUM_BLOCKS);

    logic [NUM_BLOCKS-1:0] map_reg;
    logic [NUM_BLOCKS-1:0] map_next;
    logic [MW-1:0]         hi;

    // Exclusive end of the range; blocks past the map fall away by themselves.
    assign hi = lo + len;

    // Each bit inside the range takes the new value, the rest keep theirs.
    always_comb
    begin
        map_next = map_reg;
        if (upd.upd)
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if ((MW'(i) >= lo) && (MW'(i) < hi))
                begin
                    map_next[i] = upd.set;
                end
            end
        end
    end

    // Reset leaves every block free.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg <= '0;
        end
        else
        begin
            map_reg <= map_next;
        end
    end

    assign bit_a = map_reg[addr_a];
    assign bit_b = map_reg[addr_b];

endmodule

`default_nettype wire

// File: rtl/bffa_scan.sv
// Run scanner: steps one block a cycle while step is high and counts consecutive free blocks.
`default_nettype none

module bffa_scan #(
    parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic                                        clk,
    input  wire logic                                        rst_n,
    input  wire logic                                        clr,
    input  wire logic                                        step,
    input  wire logic                                        bit_taken,
    input  wire logic [bffa_pkg::bffa_rng_w(NUM_BLOCKS)-1:0] len,
    output logic [bffa_pkg::bffa_idx_w(NUM_BLOCKS)-1:0]      pos,
    output logic [bffa_pkg::bffa_idx_w(NUM_BLOCKS)-1:0]      first_cur,
    output logic                                             found,
    output logic                                             last
);

    localparam int IDXW = bffa_pkg::bffa_idx_w(NUM_BLOCKS);
    localparam int MW   = bffa_pkg::bffa_rng_w(NUM_BLOCKS);

    logic [IDXW-1:0] pos_reg;
    logic [IDXW-1:0] pos_next;
    logic [IDXW-1:0] first_reg;
    logic [IDXW-1:0] first_next;
    logic [MW-1:0]   run_reg;
    logic [MW-1:0]   run_next;
    logic [MW-1:0]   run_inc;

    // Shared increment and compare: the run grows by one on a free block.
    assign run_inc   = run_reg + MW'(1);
    assign first_cur = (run_reg == '0) ? pos_reg : first_reg;
    assign found     = !bit_taken && (run_inc == len);
    assign last      = (pos_reg == IDXW'(NUM_BLOCKS - 1));
    assign pos       = pos_reg;

    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        run_next   = run_reg;
        if (clr)
        begin
            pos_next = '0;
            run_next = '0;
        end
        else if (step)
        begin
            pos_next   = pos_reg + IDXW'(1);
            first_next = first_cur;
            run_next   = bit_taken ? '0 : run_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            run_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            run_reg <= run_next;
        end
    end

    // The run start is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

`default_nettype wire

// File: rtl/bitmap_first_fit_block_allocator.sv
// Bitmap first-fit block allocator: sequencer, run scanner and free map.
// Allocate: accept, a scan of the map from block 0 one block at a time up to the last block,
//   a mark step and a response step.
// Free requests pass the mark step on the way to the response; check and rejected requests
//   go straight to it. No new request is taken until the response word has been loaded.
// Reset (rst_n low, asynchronous) marks every block free and empties the response.
`default_nettype none

module bitmap_first_fit_block_allocator #(
    parameter int NUM_BLOCKS = bffa_pkg::NUM_BLOCKS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bffa_req_if.sink   req,
    bffa_rsp_if.source rsp
);

    localparam int IDXW = bffa_pkg::bffa_idx_w(NUM_BLOCKS);
    localparam int MW   = bffa_pkg::bffa_rng_w(NUM_BLOCKS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_POST
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    bffa_pkg::opcode_t             op_reg;
    bffa_pkg::opcode_t             op_next;
    logic [bffa_pkg::INDEX_W-1:0]  idx_reg;
    logic [bffa_pkg::INDEX_W-1:0]  idx_next;
    logic [MW-1:0]                 lo_reg;
    logic [MW-1:0]                 lo_next;
    logic [MW-1:0]                 len_reg;
    logic [MW-1:0]                 len_next;
    logic                          fail_reg;
    logic                          fail_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_status_reg;
    logic                          out_status_next;
    logic [bffa_pkg::INDEX_W-1:0]  out_start_reg;
    logic [bffa_pkg::INDEX_W-1:0]  out_start_next;
    logic                          out_taken_reg;
    logic                          out_taken_next;

    logic                          accept;
    logic [MW-1:0]                 cnt_ext;
    logic [MW-1:0]                 idx_ext;
    logic [MW-1:0]                 req_idx_ext;
    logic [IDXW-1:0]               chk_addr;
    bffa_pkg::bffa_upd_t           upd;
    logic                          bit_scan;
    logic                          bit_chk;
    logic [IDXW-1:0]               scan_pos;
    logic [IDXW-1:0]               scan_first;
    logic                          scan_found;
    logic                          scan_last;

    assign accept      = req.valid && req.ready;
    assign req.ready   = (state_reg == S_IDLE);
    assign cnt_ext     = MW'(req.run_length);
    assign req_idx_ext = MW'(req.block_index);
    assign idx_ext     = MW'(idx_reg);
    assign chk_addr    = idx_ext[IDXW-1:0];

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.first_block = out_start_reg;
    assign rsp.block_taken = out_taken_reg;

    // The mark cycle sets an allocated run or clears a freed range.
    always_comb
    begin
        upd.upd = (state_reg == S_MARK);
        upd.set = (op_reg == bffa_pkg::OPC_ALLOC);
    end

    bffa_map #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd),
        .lo     (lo_reg),
        .len    (len_reg),
        .addr_a (scan_pos),
        .addr_b (chk_addr),
        .bit_a  (bit_scan),
        .bit_b  (bit_chk)
    );

    bffa_scan #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (accept),
        .step      (state_reg == S_SCAN),
        .bit_taken (bit_scan),
        .len       (len_reg),
        .pos       (scan_pos),
        .first_cur (scan_first),
        .found     (scan_found),
        .last      (scan_last)
    );

    // Sequencer next state and response word.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        len_next        = len_reg;
        fail_next       = fail_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        out_taken_next  = out_taken_reg;

        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = req.opcode;
                    idx_next  = req.block_index;
                    lo_next   = req_idx_ext;
                    len_next  = cnt_ext;
                    fail_next = 1'b0;
                    unique case (req.opcode)
                        bffa_pkg::OPC_ALLOC:
                        begin
                            if ((cnt_ext == '0) || (cnt_ext > MW'(NUM_BLOCKS)))
                            begin
                                fail_next  = 1'b1;
                                state_next = S_POST;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        bffa_pkg::OPC_FREE:
                        begin
                            state_next = S_MARK;
                        end
                        bffa_pkg::OPC_CHECK:
                        begin
                            fail_next  = (req_idx_ext >= MW'(NUM_BLOCKS));
                            state_next = S_POST;
                        end
                        default:
                        begin
                            fail_next  = 1'b1;
                            state_next = S_POST;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_found)
                begin
                    lo_next    = MW'(scan_first);
                    state_next = S_MARK;
                end
                else if (scan_last)
                begin
                    fail_next  = 1'b1;
                    state_next = S_POST;
                end
            end
            S_MARK:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                // Load the response once the output register is empty or draining.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = fail_reg ? bffa_pkg::STATUS_FAIL : bffa_pkg::STATUS_OK;
                    out_start_next  = ((op_reg == bffa_pkg::OPC_ALLOC) && !fail_reg)
                                      ? lo_reg[bffa_pkg::INDEX_W-1:0] : '0;
                    out_taken_next  = (op_reg == bffa_pkg::OPC_CHECK) && !fail_reg && bit_chk;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and response payload.
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        len_reg        <= len_next;
        fail_reg       <= fail_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
        out_taken_reg  <= out_taken_next;
    end

endmodule

`default_nettype wire

// File: rtl/bffa_checker.sv
// Port-level checks of the block allocator and their binding to the top level.
`default_nettype none

module bffa_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         rsp_valid,
    input wire logic                         rsp_ready,
    input wire logic                         rsp_status,
    input wire logic [bffa_pkg::INDEX_W-1:0] rsp_first_block,
    input wire logic                         rsp_block_taken
);

    // A stalled response word holds until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_first_block) && $stable(rsp_block_taken))
        else $error("response word changed while stalled");

    // The block works on one request at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // A nonzero first block only comes with a successful allocation.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_first_block != '0) |-> !rsp_status && !rsp_block_taken)
        else $error("first block reported outside a successful allocation");

    // A taken block is only reported by a successful check.
    a_taken: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_block_taken |-> !rsp_status)
        else $error("block taken reported with failure status");

endmodule

bind bitmap_first_fit_block_allocator bffa_checker u_bffa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_first_block (rsp.first_block),
    .rsp_block_taken (rsp.block_taken)
);

`default_nettype wire

// File: test/tb_bitmap_first_fit_block_allocator.sv
// Self-checking testbench for the bitmap first-fit block allocator.
module tb_bitmap_first_fit_block_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = bffa_pkg::NUM_BLOCKS_DEF;
    localparam bffa_pkg::opcode_t OPC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = NB + 16;
    localparam int MAX_PRINTED = 40;

    // One request word plus the idle time the driver leaves after it.
    typedef struct {
        bffa_pkg::opcode_t                opcode;
        logic [bffa_pkg::INDEX_W-1:0]     block_index;
        logic [bffa_pkg::COUNT_W-1:0]     run_length;
        int unsigned                      gap;
    } alloc_word_t;

    typedef struct packed {
        logic                         status;
        logic [bffa_pkg::INDEX_W-1:0] first_block;
        logic                         block_taken;
    } reply_t;

    logic clk;
    logic rst_n;

    bffa_req_if req_ch ();
    bffa_rsp_if rsp_ch ();

    bitmap_first_fit_block_allocator #(
        .NUM_BLOCKS(NB)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Testbench copy of the free map: 1 means taken.
    logic [NB-1:0] taken_map = '0;

    alloc_word_t pending_words[$];
    reply_t      expected_replies[$];
    alloc_word_t sent_word;

    int unsigned req_gap;
    int unsigned rsp_stall;
    int unsigned rsp_mode;
    int unsigned rsp_cycles;

    int mismatches = 0;
    int n_alloc    = 0;
    int n_free     = 0;
    int n_check    = 0;
    int n_other    = 0;
    int n_replies  = 0;

    // Work out the reply to one request and apply it to the map copy.
    function automatic reply_t predict_reply(input alloc_word_t w);
        reply_t r;
        int     len;
        int     run;
        int     first;
        int     b;
        int     k;
        r     = '0;
        len   = int'(w.run_length);
        run   = 0;
        first = 0;
        case (w.opcode)
            bffa_pkg::OPC_ALLOC: begin
                r.status = bffa_pkg::STATUS_FAIL;
                if (len != 0 && len <= NB) begin
                    for (b = 0; b < NB; b++) begin
                        if (!taken_map[b]) begin
                            if (run == 0)
                                first = b;
                            run++;
                            if (run == len) begin
                                for (k = 0; k < len; k++)
                                    taken_map[first + k] = 1'b1;
                                r.status      = bffa_pkg::STATUS_OK;
                                r.first_block = bffa_pkg::INDEX_W'(first);
                                break;
                            end
                        end else begin
                            run = 0;
                        end
                    end
                end
            end
            bffa_pkg::OPC_FREE: begin
                // Blocks past the end of the map are simply skipped.
                for (k = 0; k < len; k++) begin
                    b = int'(w.block_index) + k;
                    if (b < NB)
                        taken_map[b] = 1'b0;
                end
                r.status = bffa_pkg::STATUS_OK;
            end
            bffa_pkg::OPC_CHECK: begin
                if (int'(w.block_index) >= NB) begin
                    r.status = bffa_pkg::STATUS_FAIL;
                end else begin
                    r.status      = bffa_pkg::STATUS_OK;
                    r.block_taken = taken_map[w.block_index];
                end
            end
            default: r.status = bffa_pkg::STATUS_FAIL;
        endcase
        return r;
    endfunction

    // Length of one idle stretch: mostly short, a few long.
    function automatic int unsigned stall_length();
        if ($urandom_range(0, 99) < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // Idle time after a word; mode 0 means back-to-back.
    function automatic int unsigned pick_gap(input int unsigned mode);
        if (mode == 0 || $urandom_range(0, 99) >= mode * 15)
            return 0;
        return stall_length();
    endfunction

    task automatic push_word(input bffa_pkg::opcode_t op, input int idx, input int cnt,
                             input int unsigned mode);
        alloc_word_t w;
        w.opcode      = op;
        w.block_index = bffa_pkg::INDEX_W'(idx);
        w.run_length  = bffa_pkg::COUNT_W'(cnt);
        w.gap         = pick_gap(mode);
        pending_words.push_back(w);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Clock.
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Request driver: presents queued words and predicts each accepted one.
    always @(posedge clk or negedge rst_n) begin : drive_requests
        alloc_word_t w;
        logic        slot_free;
        if (!rst_n) begin
            req_ch.valid       <= 1'b0;
            req_ch.opcode      <= bffa_pkg::OPC_ALLOC;
            req_ch.block_index <= '0;
            req_ch.run_length  <= '0;
            req_gap = 0;
        end else begin
            slot_free = !req_ch.valid;
            if (req_ch.valid && req_ch.ready) begin
                expected_replies.push_back(predict_reply(sent_word));
                case (sent_word.opcode)
                    bffa_pkg::OPC_ALLOC: n_alloc++;
                    bffa_pkg::OPC_FREE:  n_free++;
                    bffa_pkg::OPC_CHECK: n_check++;
                    default:             n_other++;
                endcase
                slot_free = 1'b1;
            end
            if (slot_free) begin
                if (req_gap > 0) begin
                    req_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    sent_word = w;
                    req_ch.opcode      <= w.opcode;
                    req_ch.block_index <= w.block_index;
                    req_ch.run_length  <= w.run_length;
                    req_ch.valid       <= 1'b1;
                    req_gap = w.gap;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: checks each accepted word and throttles ready.
    always @(posedge clk or negedge rst_n) begin : check_replies
        reply_t want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            rsp_stall  = 0;
            rsp_mode   = 0;
            rsp_cycles = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                n_replies++;
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply word with no request outstanding");
                end else begin
                    want = expected_replies.pop_front();
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("status got %0b want %0b",
                                                  rsp_ch.status, want.status));
                    if (rsp_ch.first_block !== want.first_block)
                        report_mismatch($sformatf("first_block got %0d want %0d",
                                                  rsp_ch.first_block, want.first_block));
                    if (rsp_ch.block_taken !== want.block_taken)
                        report_mismatch($sformatf("block_taken got %0b want %0b",
                                                  rsp_ch.block_taken, want.block_taken));
                end
            end

            // Back-pressure changes character at intervals counted by rsp_cycles.
            rsp_cycles++;
            if (rsp_cycles % 1024 == 0)
                rsp_mode = $urandom_range(0, 3);
            if (rsp_stall > 0) begin
                rsp_stall--;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_mode != 0 && $urandom_range(0, 99) < rsp_mode * 8) begin
                rsp_stall = stall_length() - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : main_flow
        int          i;
        int unsigned p;
        int unsigned q;
        int unsigned seg_mode;
        rst_n = 1'b0;

        // Directed part: invalid lengths, full map, frees past the end, holes.
        push_word(bffa_pkg::OPC_ALLOC, 0, 0, 2);
        push_word(bffa_pkg::OPC_ALLOC, 63, NB + 1, 2);
        push_word(bffa_pkg::OPC_ALLOC, 0, 127, 2);
        push_word(bffa_pkg::OPC_CHECK, 0, 0, 2);
        push_word(bffa_pkg::OPC_ALLOC, 0, NB, 2);
        push_word(bffa_pkg::OPC_CHECK, 63, 127, 2);
        push_word(bffa_pkg::OPC_ALLOC, 0, 1, 2);
        push_word(bffa_pkg::OPC_FREE, 60, NB, 2);
        push_word(bffa_pkg::OPC_CHECK, 63, 0, 2);
        push_word(bffa_pkg::OPC_CHECK, 59, 0, 2);
        push_word(bffa_pkg::OPC_FREE, 63, 0, 2);
        push_word(bffa_pkg::OPC_CHECK, 60, 0, 2);
        push_word(OPC_UNUSED, 63, 127, 2);
        push_word(OPC_UNUSED, 0, 0, 2);
        push_word(bffa_pkg::OPC_FREE, 0, 127, 2);
        push_word(bffa_pkg::OPC_ALLOC, 0, 1, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, 3, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, 2, 0);
        push_word(bffa_pkg::OPC_FREE, 1, 2, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, 2, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, 2, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, 1, 0);
        push_word(bffa_pkg::OPC_ALLOC, 0, NB - 8, 0);
        push_word(bffa_pkg::OPC_CHECK, 63, 0, 0);
        push_word(bffa_pkg::OPC_FREE, 0, NB, 0);

        // Random part: mostly allocate and free traffic that fragments the map.
        seg_mode = 0;
        for (i = 0; i < 1450; i++) begin
            if (i % 100 == 0)
                seg_mode = $urandom_range(0, 3);
            p = $urandom_range(0, 99);
            q = $urandom_range(0, 9);
            if (p < 45) begin
                if (q < 7)
                    push_word(bffa_pkg::OPC_ALLOC, $urandom_range(0, 63),
                              $urandom_range(1, 8), seg_mode);
                else if (q < 9)
                    push_word(bffa_pkg::OPC_ALLOC, $urandom_range(0, 63),
                              $urandom_range(9, 32), seg_mode);
                else
                    push_word(bffa_pkg::OPC_ALLOC, $urandom_range(0, 63),
                              $urandom_range(33, NB), seg_mode);
            end else if (p < 72) begin
                if (q < 8)
                    push_word(bffa_pkg::OPC_FREE, $urandom_range(0, 63),
                              $urandom_range(1, 8), seg_mode);
                else
                    push_word(bffa_pkg::OPC_FREE, $urandom_range(0, 63),
                              $urandom_range(9, NB), seg_mode);
            end else if (p < 77) begin
                // Wide release keeps the map from filling up for good.
                push_word(bffa_pkg::OPC_FREE, $urandom_range(0, 15),
                          $urandom_range(32, NB), seg_mode);
            end else if (p < 93) begin
                push_word(bffa_pkg::OPC_CHECK, $urandom_range(0, 63),
                          $urandom_range(0, 127), seg_mode);
            end else begin
                case (q % 4)
                    0: push_word(OPC_UNUSED, $urandom_range(0, 63), $urandom_range(0, 127),
                                 seg_mode);
                    1: push_word(bffa_pkg::OPC_ALLOC, $urandom_range(0, 63), 0, seg_mode);
                    2: push_word(bffa_pkg::OPC_ALLOC, $urandom_range(0, 63),
                                 $urandom_range(NB + 1, 127), seg_mode);
                    default: push_word(bffa_pkg::OPC_FREE, $urandom_range(0, 63),
                                       $urandom_range(NB + 1, 127), seg_mode);
                endcase
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every word to go in and every reply to come back.
        while (pending_words.size() != 0 || req_ch.valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_replies.size() != 0)
            report_mismatch($sformatf("%0d replies never arrived", expected_replies.size()));

        $display("Covered %0d allocate, %0d free, %0d check and %0d unused-opcode requests.",
                 n_alloc, n_free, n_check, n_other);
        $display("Checked %0d reply words; %0d field mismatches.", n_replies, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #(20_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/bffa_pkg.sv
rtl/bffa_if.sv
rtl/bffa_map.sv
rtl/bffa_scan.sv
rtl/bitmap_first_fit_block_allocator.sv
rtl/bffa_checker.sv
test/tb_bitmap_first_fit_block_allocator.sv
